/* rtl/core/mbpm_pkg.sv */
// Shared definitions for the multi bracket pair matcher.
// Holds sizes, register indexes, reset values and the front-to-back op and result types.
// Depends on nothing.
package mbpm_pkg;

	localparam int PAIR_TYPES_DEF  = 4;
	localparam int STACK_DEPTH_DEF = 256;
	localparam int MAX_LEN_DEF     = 4096;

	localparam int SYM_W       = 8;
	localparam int POS_W       = 12;
	localparam int KEY_BYTES   = 4;
	localparam int TYPE_W      = 2;
	localparam int CNT_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int OUT_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OPEN_CHARS       = 3'd0,
		REG_CLOSE_CHARS      = 3'd1,
		REG_PAIR_TYPES_USED  = 3'd2,
		REG_BREAK_CHARS      = 3'd3,
		REG_BREAK_CHARS_USED = 3'd4
	} cfg_reg_t;

	localparam logic [CFG_DATA_W-1:0] OPEN_CHARS_RST       = 32'd1013144360;
	localparam logic [CFG_DATA_W-1:0] CLOSE_CHARS_RST      = 32'd1046307113;
	localparam logic [CNT_W-1:0]      PAIR_TYPES_USED_RST  = 3'd4;
	localparam logic [CFG_DATA_W-1:0] BREAK_CHARS_RST      = 32'd38;
	localparam logic [CNT_W-1:0]      BREAK_CHARS_USED_RST = 3'd1;

	typedef struct packed {
		logic              brk;
		logic              is_open;
		logic              is_close;
		logic [TYPE_W-1:0] kind;
		logic              last;
	} op_t;

	typedef struct packed {
		logic             error_seen;
		logic [POS_W-1:0] close_pos;
		logic [POS_W-1:0] open_pos;
	} res_t;

endpackage

/* rtl/core/mbpm_front.sv */
// Front end: configuration registers and character classification.
// Turns each accepted character into an op for the queue. Uses mbpm_pkg.
module mbpm_front
	import mbpm_pkg::*;
#(
	parameter int PAIR_TYPES = PAIR_TYPES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SYM_W-1:0]      s_tdata,
	input  logic                  s_tlast,
	output logic                  q_valid,
	input  logic                  q_ready,
	output op_t                   q_op
);

	localparam int NCMP = (PAIR_TYPES < KEY_BYTES) ? PAIR_TYPES : KEY_BYTES;

	logic [CFG_DATA_W-1:0] open_chars_q;
	logic [CFG_DATA_W-1:0] close_chars_q;
	logic [CFG_DATA_W-1:0] break_chars_q;
	logic [CNT_W-1:0]      pair_types_q;
	logic [CNT_W-1:0]      break_used_q;

	logic [CNT_W-1:0]  n_types;
	logic [CNT_W-1:0]  n_breaks;
	logic              brk_hit;
	logic              open_hit;
	logic              close_hit;
	logic [TYPE_W-1:0] open_idx;
	logic [TYPE_W-1:0] close_idx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_chars_q  <= OPEN_CHARS_RST;
			close_chars_q <= CLOSE_CHARS_RST;
			pair_types_q  <= PAIR_TYPES_USED_RST;
			break_chars_q <= BREAK_CHARS_RST;
			break_used_q  <= BREAK_CHARS_USED_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OPEN_CHARS:       open_chars_q  <= cfg_data;
				REG_CLOSE_CHARS:      close_chars_q <= cfg_data;
				REG_PAIR_TYPES_USED:  pair_types_q  <= cfg_data[CNT_W-1:0];
				REG_BREAK_CHARS:      break_chars_q <= cfg_data;
				REG_BREAK_CHARS_USED: break_used_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		n_types   = (pair_types_q > CNT_W'(NCMP)) ? CNT_W'(NCMP) : pair_types_q;
		n_breaks  = (break_used_q > CNT_W'(KEY_BYTES)) ? CNT_W'(KEY_BYTES) : break_used_q;
		brk_hit   = 1'b0;
		open_hit  = 1'b0;
		close_hit = 1'b0;
		open_idx  = '0;
		close_idx = '0;
		for (int t = 0; t < KEY_BYTES; t++) begin
			if (CNT_W'(t) < n_breaks && break_chars_q[t*SYM_W +: SYM_W] == s_tdata) begin
				brk_hit = 1'b1;
			end
		end
		for (int t = 0; t < NCMP; t++) begin
			if (!open_hit && CNT_W'(t) < n_types &&
			    open_chars_q[t*SYM_W +: SYM_W] == s_tdata) begin
				open_hit = 1'b1;
				open_idx = TYPE_W'(t);
			end
			if (!close_hit && CNT_W'(t) < n_types &&
			    close_chars_q[t*SYM_W +: SYM_W] == s_tdata) begin
				close_hit = 1'b1;
				close_idx = TYPE_W'(t);
			end
		end
	end

	assign q_valid       = s_tvalid;
	assign s_tready      = q_ready;
	assign q_op.brk      = brk_hit;
	assign q_op.is_open  = open_hit;
	assign q_op.is_close = close_hit;
	assign q_op.kind     = open_hit ? open_idx : close_idx;
	assign q_op.last     = s_tlast;

endmodule

/* rtl/core/mbpm_queue.sv */
// Short queue of classified ops between the front and back ends.
// Lets either side stall on its own. Uses mbpm_pkg.
module mbpm_queue
	import mbpm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  op_t  in_op,
	output logic out_valid,
	input  logic out_ready,
	output op_t  out_op
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	op_t           slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = count_q != CW'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_op    = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_op;
		end
	end

endmodule

/* rtl/core/mbpm_back.sv */
// Back end: stack heights, position, error flag and the stack memory.
// Executes one queued op per cycle while its result register is free, and registers the matched pair. Uses mbpm_pkg.
module mbpm_back
	import mbpm_pkg::*;
#(
	parameter int PAIR_TYPES  = PAIR_TYPES_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int MAX_LEN     = MAX_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_ready,
	input  op_t  op,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int NT  = (PAIR_TYPES < KEY_BYTES) ? PAIR_TYPES : KEY_BYTES;
	localparam int TW  = (NT > 1) ? $clog2(NT) : 1;
	localparam int HW  = $clog2(STACK_DEPTH);
	localparam int HCW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = TW + HW;
	localparam logic [POS_W-1:0] POS_LIMIT =
		POS_W'((MAX_LEN > (1 << POS_W)) ? ((1 << POS_W) - 1) : (MAX_LEN - 1));

	logic [HCW-1:0]   heights_q [NT];
	logic [POS_W-1:0] pos_q;
	logic             err_q;
	logic [POS_W-1:0] stack_mem [2**AW];

	logic             valid_s2;
	logic [POS_W-1:0] open_pos_s2;
	logic [POS_W-1:0] close_pos_s2;
	logic             err_s2;

	logic           stage_free;
	logic           fire;
	logic [TW-1:0]  ti;
	logic [HCW-1:0] h;
	logic [HCW-1:0] h_m1;
	logic           do_push;
	logic           drop;
	logic           do_pop;
	logic           sat;
	logic           err_nxt;
	logic [AW-1:0]  wr_addr;
	logic [AW-1:0]  rd_addr;

	assign stage_free = !valid_s2 || res_ready;
	assign op_ready   = stage_free;
	assign fire       = op_valid && stage_free;
	assign ti         = op.kind[TW-1:0];
	assign h          = heights_q[ti];
	assign h_m1       = h - HCW'(1);
	assign do_push    = !op.brk && op.is_open && h != HCW'(STACK_DEPTH);
	assign drop       = !op.brk && op.is_open && h == HCW'(STACK_DEPTH);
	assign do_pop     = !op.brk && !op.is_open && op.is_close && h != '0;
	assign sat        = !op.brk && pos_q == POS_LIMIT;
	assign err_nxt    = err_q || drop || sat;
	assign wr_addr    = {ti, h[HW-1:0]};
	assign rd_addr    = {ti, h_m1[HW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NT; i++) begin
				heights_q[i] <= '0;
			end
			pos_q    <= '0;
			err_q    <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				if (op.last) begin
					for (int i = 0; i < NT; i++) begin
						heights_q[i] <= '0;
					end
					pos_q <= '0;
					err_q <= 1'b0;
				end else begin
					if (do_push) begin
						heights_q[ti] <= h + HCW'(1);
					end else if (do_pop) begin
						heights_q[ti] <= h_m1;
					end
					if (!op.brk && !sat) begin
						pos_q <= pos_q + POS_W'(1);
					end
					err_q <= err_nxt;
				end
			end
			if (stage_free) begin
				valid_s2 <= fire && do_pop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_push) begin
			stack_mem[wr_addr] <= pos_q;
		end
		if (fire && do_pop) begin
			open_pos_s2  <= stack_mem[rd_addr];
			close_pos_s2 <= pos_q;
			err_s2       <= err_nxt;
		end
	end

	assign res_valid      = valid_s2;
	assign res.open_pos   = open_pos_s2;
	assign res.close_pos  = close_pos_s2;
	assign res.error_seen = err_s2;

`ifndef ASSERT_OFF
	a_height_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> h <= HCW'(STACK_DEPTH))
		else $error("stack height beyond depth");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LIMIT)
		else $error("position beyond limit");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op.last |=> pos_q == '0 && !err_q)
		else $error("string state not cleared after last character");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && !(fire && op.last) |=> err_q)
		else $error("error flag dropped inside a string");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(fire && do_pop))
		else $error("result without a pop");
`endif

endmodule

/* rtl/core/multi_bracket_pair_matcher.sv */
// Top level of the multi bracket pair matcher: front end, op queue and back end.
// Depends on mbpm_pkg, mbpm_front, mbpm_queue and mbpm_back.
//
// The block reads a structure string one character per transaction and reports
// each matched pair as (open position, close position, error flag). It sustains
// one character per clock cycle while results are taken, since the back end does
// at most one stack push or pop per cycle. A closing character is first written
// into the queue, and the popped entry is then read through a registered memory
// output that also holds the result. A four-entry queue separates classification
// from execution, so up to four characters can be taken while a result waits. The
// stack memory needs no clearing pass after reset. Configuration writes are taken
// at any time but are meant for idle periods.
module multi_bracket_pair_matcher
	import mbpm_pkg::*;
#(
	parameter int PAIR_TYPES  = PAIR_TYPES_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int MAX_LEN     = MAX_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SYM_W-1:0]      s_tdata,  // symbol[7:0]
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // open_pos[11:0], close_pos[23:12], error_seen[24]
);

	logic q_in_valid;
	logic q_in_ready;
	op_t  q_in_op;
	logic q_out_valid;
	logic q_out_ready;
	op_t  q_out_op;
	res_t res;

	mbpm_front #(
		.PAIR_TYPES (PAIR_TYPES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_valid   (q_in_valid),
		.q_ready   (q_in_ready),
		.q_op      (q_in_op)
	);

	mbpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_in_valid),
		.in_ready  (q_in_ready),
		.in_op     (q_in_op),
		.out_valid (q_out_valid),
		.out_ready (q_out_ready),
		.out_op    (q_out_op)
	);

	mbpm_back #(
		.PAIR_TYPES  (PAIR_TYPES),
		.STACK_DEPTH (STACK_DEPTH),
		.MAX_LEN     (MAX_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_out_valid),
		.op_ready  (q_out_ready),
		.op        (q_out_op),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {(OUT_DATA_W - $bits(res_t))'(0), res};

endmodule
